### rtl/bbp_pkg.sv
// Package for the bimodal branch predictor: the counter type, its constants,
// the table request struct and the counter update functions. No dependencies.
package bbp_pkg;

    localparam int IdxWMax = 20;

    typedef logic [2:0]  t_ctr;
    typedef logic [31:0] t_count;
    typedef logic [3:0]  t_index_bits;

    localparam t_ctr        CtrInit        = 3'd4;
    localparam t_ctr        CtrMax         = 3'd7;
    localparam t_ctr        CtrMin         = 3'd0;
    localparam t_ctr        TakenThreshold = 3'd4;
    localparam t_count      CountMax       = 32'hFFFF_FFFF;
    localparam t_index_bits IndexBitsReset = 4'd12;

    typedef struct packed {
        logic               rd_en;
        logic [IdxWMax-1:0] rd_idx;
        logic               wr_en;
        logic [IdxWMax-1:0] wr_idx;
        t_ctr               wr_data;
    } t_tbl_req;

    // Moves a 3-bit counter one step toward the resolved outcome.
    function automatic t_ctr ctr_step(input t_ctr ctr, input logic taken);
        t_ctr res;
        res = ctr;
        if (taken) begin
            if (ctr != CtrMax) res = ctr + 3'd1;
        end else begin
            if (ctr != CtrMin) res = ctr - 3'd1;
        end
        return res;
    endfunction

    function automatic t_count sat_inc(input t_count v);
        return (v == CountMax) ? v : v + 32'd1;
    endfunction

endpackage

### rtl/bbp_if.sv
// Handshake interfaces of the bimodal branch predictor: the resolved branch
// channel and the result channel. No dependencies.
interface bbp_branch_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_address;
    logic        actual_taken;

    modport source (output valid, branch_address, actual_taken, input ready);
    modport sink   (input valid, branch_address, actual_taken, output ready);
endinterface

interface bbp_result_if;
    logic        valid;
    logic        ready;
    logic        predicted_taken;
    logic        mispredicted;
    logic [2:0]  updated_counter;
    logic [31:0] total_predictions;
    logic [31:0] total_mispredictions;

    modport source (output valid, predicted_taken, mispredicted, updated_counter,
                    total_predictions, total_mispredictions, input ready);
    modport sink   (input valid, predicted_taken, mispredicted, updated_counter,
                    total_predictions, total_mispredictions, output ready);
endinterface

### rtl/bbp_ctr_table.sv
// Counter table of the bimodal branch predictor: one synchronous memory with a
// registered read port, a write port and a clearing sweep after reset. Uses bbp_pkg.
module bbp_ctr_table import bbp_pkg::*; #(
    parameter int IDX_W = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_ctr     o_rd_data,
    output logic     o_busy
);

    localparam int Depth = 1 << IDX_W;

    t_ctr             mem [Depth];
    t_ctr             r_rd_data;
    logic             r_clr_active;
    logic [IDX_W-1:0] r_clr_idx;

    // Sweep every entry back to weakly taken, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {IDX_W{1'b1}}) r_clr_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem[r_clr_idx] <= CtrInit;
        end else if (i_req.wr_en) begin
            mem[i_req.wr_idx[IDX_W-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) r_rd_data <= mem[i_req.rd_idx[IDX_W-1:0]];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_active;

endmodule

### rtl/bimodal_branch_predictor.sv
// Top level of the bimodal branch predictor with 3-bit saturating counters.
// Depends on bbp_pkg, the interfaces in bbp_if and bbp_ctr_table.
//
// Usage:
// Resolved branches arrive on i_branch (valid/ready); an item is taken at a
// rising edge with valid and ready both high. Each item gives one result item
// on o_result: the prediction made from the counter before the update, the
// misprediction flag, the counter written back, and the running prediction
// and misprediction counts, both saturating at all ones.
// The index register (i_cfg_we, i_cfg_wdata) sets how many address bits,
// starting at bit 2, select the counter; values above MAX_INDEX_BITS act as
// MAX_INDEX_BITS and zero maps every branch to entry 0. Write it only while
// the block is idle.
// An accepted item passes the read stage and the output register before its
// result shows. Throughput: one item per cycle while o_result is not held. The
// counter memory is read in the cycle an item is accepted and written when the
// item leaves the read stage; a branch that hits the entry written by the item
// just ahead takes the new counter from a forwarding register, not the memory.
// Reset: synchronous and active low. Afterwards the counter table is swept to
// weakly taken (4), one entry per cycle, over all 2**MAX_INDEX_BITS entries;
// ready stays low meanwhile. Counts restart at zero, the index register at 12.
// Stall: while o_result is held, one more item can be taken into the read
// stage; after that ready drops until the output register drains.
module bimodal_branch_predictor import bbp_pkg::*; #(
    parameter int MAX_INDEX_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    bbp_branch_if.sink         i_branch,
    bbp_result_if.source       o_result
);

    localparam int IdxW = MAX_INDEX_BITS;

    // Configuration register.
    t_index_bits r_index_bits;

    // Read stage: the item waits here while its counter is read.
    logic            r_s1_valid;
    logic [IdxW-1:0] r_s1_idx;
    logic            r_s1_taken;
    logic            r_fwd_valid;
    t_ctr            r_fwd_ctr;

    // Output register and running counts.
    logic            r_out_valid;
    logic            r_out_pred;
    logic            r_out_miss;
    t_ctr            r_out_ctr;
    t_count          r_pred_cnt;
    t_count          r_mis_cnt;

    logic            s1_adv;
    logic            in_ready;
    logic            accept;
    logic [IdxW-1:0] idx_mask;
    logic [IdxW-1:0] addr_idx;
    t_ctr            ctr_cur;
    t_ctr            n_ctr;
    logic            predicted;
    logic            miss;
    t_count          n_pred_cnt;
    t_count          n_mis_cnt;
    t_tbl_req        tbl_req;
    t_ctr            tbl_rd_data;
    logic            tbl_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= IndexBitsReset;
        end else if (i_cfg_we) begin
            r_index_bits <= i_cfg_wdata;
        end
    end

    // Bit i of the index is kept when i is below the configured width, so a
    // width beyond the table simply keeps every bit.
    always_comb begin
        for (int i = 0; i < IdxW; i++) begin
            idx_mask[i] = (5'(i) < {1'b0, r_index_bits});
        end
    end

    assign addr_idx = i_branch.branch_address[IdxW+1:2] & idx_mask;

    // The read stage moves on whenever the output register is free or drains.
    assign s1_adv   = r_s1_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !tbl_busy && (!r_s1_valid || s1_adv);
    assign accept   = i_branch.valid && in_ready;
    assign i_branch.ready = in_ready;

    // The memory read issued at acceptance misses a write to the same entry
    // made at that same edge, so that value comes from the forwarding register.
    assign ctr_cur    = r_fwd_valid ? r_fwd_ctr : tbl_rd_data;
    assign predicted  = (ctr_cur >= TakenThreshold);
    assign miss       = (predicted != r_s1_taken);
    assign n_ctr      = ctr_step(ctr_cur, r_s1_taken);
    assign n_pred_cnt = sat_inc(r_pred_cnt);
    assign n_mis_cnt  = miss ? sat_inc(r_mis_cnt) : r_mis_cnt;

    always_comb begin
        tbl_req         = '0;
        tbl_req.rd_en   = accept;
        tbl_req.rd_idx  = IdxWMax'(addr_idx);
        tbl_req.wr_en   = s1_adv;
        tbl_req.wr_idx  = IdxWMax'(r_s1_idx);
        tbl_req.wr_data = n_ctr;
    end

    bbp_ctr_table #(
        .IDX_W (IdxW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd_data),
        .o_busy    (tbl_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid  <= 1'b1;
            r_fwd_valid <= s1_adv && (r_s1_idx == addr_idx);
        end else if (s1_adv) begin
            r_s1_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx   <= addr_idx;
            r_s1_taken <= i_branch.actual_taken;
            r_fwd_ctr  <= n_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pred_cnt  <= '0;
            r_mis_cnt   <= '0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
            r_pred_cnt  <= n_pred_cnt;
            r_mis_cnt   <= n_mis_cnt;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pred <= predicted;
            r_out_miss <= miss;
            r_out_ctr  <= n_ctr;
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.predicted_taken      = r_out_pred;
    assign o_result.mispredicted         = r_out_miss;
    assign o_result.updated_counter      = r_out_ctr;
    assign o_result.total_predictions    = r_pred_cnt;
    assign o_result.total_mispredictions = r_mis_cnt;

endmodule

### rtl/bbp_checker.sv
// Port-level checks for the bimodal branch predictor, bound to the top level.
// Depends only on the top level's ports.
module bbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_pred,
    input logic        i_miss,
    input logic [2:0]  i_ctr,
    input logic [31:0] i_total_pred,
    input logic [31:0] i_total_miss
);

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A correct taken prediction pushes the counter above the threshold.
    a_hit_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_pred && !i_miss) |-> (i_ctr >= 3'd5))
        else $error("counter too low after correct taken prediction");

    // A correct not-taken prediction pulls the counter well below it.
    a_hit_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_pred && !i_miss) |-> (i_ctr <= 3'd2))
        else $error("counter too high after correct not-taken prediction");

    // Mispredictions never outnumber predictions, and a miss is counted.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_total_miss <= i_total_pred) &&
                         (!i_miss || i_total_miss != 32'd0)))
        else $error("inconsistent prediction counts");

    // Each delivered item is followed by one with a higher count unless saturated.
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) ##1 i_out_valid |->
            (i_total_pred != $past(i_total_pred) || i_total_pred == 32'hFFFF_FFFF))
        else $error("prediction count did not advance");

endmodule

bind bimodal_branch_predictor bbp_checker u_bbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_pred       (o_result.predicted_taken),
    .i_miss       (o_result.mispredicted),
    .i_ctr        (o_result.updated_counter),
    .i_total_pred (o_result.total_predictions),
    .i_total_miss (o_result.total_mispredictions)
);
